[rtl/wlf_pkg.sv]
package wlf_pkg;

   // Widths of the five point sums.
   localparam int SW_W   = 20;   // sum of weights
   localparam int S1_W   = 36;   // sums of w*z and w*t
   localparam int S2_W   = 52;   // sums of w*z*z and w*z*t

   // Point multiplier: 28-bit signed by 16-bit signed.
   localparam int MA_W   = 28;
   localparam int MB_W   = 16;
   localparam int MP_W   = MA_W + MB_W;

   // Shared wide adder and the registers around it.
   localparam int WIDE_W = 104;
   localparam int DEN_W  = 72;   // positive denominator
   localparam int MUL_W  = 36;   // multiplier magnitude, also the quotient shifter
   localparam int Q_W    = 32;   // quotient bits kept
   localparam int QCNT_W = 5;    // counts Q_W division steps

   // Product terms of the fit, in the order they are formed.
   localparam logic [2:0] T_DEN_A   = 3'd0;   // + Sw  * Szz
   localparam logic [2:0] T_DEN_B   = 3'd1;   // - Sz  * Sz
   localparam logic [2:0] T_ICPT_A  = 3'd2;   // + St  * Szz
   localparam logic [2:0] T_ICPT_B  = 3'd3;   // - Sz  * Szt
   localparam logic [2:0] T_SLOPE_A = 3'd4;   // + Sw  * Szt * 2^16
   localparam logic [2:0] T_SLOPE_B = 3'd5;   // - Sz  * St  * 2^16

   // Point accumulation steps, named after the product launched in each.
   localparam logic [2:0] STEP_WZ  = 3'd0;
   localparam logic [2:0] STEP_WT  = 3'd1;
   localparam logic [2:0] STEP_WZZ = 3'd2;
   localparam logic [2:0] STEP_WZT = 3'd3;
   localparam logic [2:0] STEP_END = 3'd4;

   typedef enum logic [9:0] {
      S_IDLE = 10'b00_0000_0001,
      S_ACC  = 10'b00_0000_0010,
      S_LOAD = 10'b00_0000_0100,
      S_MUL  = 10'b00_0000_1000,
      S_TEST = 10'b00_0001_0000,
      S_ABS  = 10'b00_0010_0000,
      S_PREP = 10'b00_0100_0000,
      S_DIV  = 10'b00_1000_0000,
      S_DONE = 10'b01_0000_0000,
      S_OUT  = 10'b10_0000_0000
   } state_type;

endpackage

[rtl/weighted_line_fit.sv]
// Each accepted request is latched, then runs 5 accumulation steps on one small
// multiplier; no new point is taken until these steps are done.
// A request marked last then runs the fit on one shared 104-bit adder: six shift-add
// products and two divisions, or only the two denominator products for a degenerate set.
// The response waits in an output register while the next set is accepted.
// Synchronous active-high reset clears the sums, the point count and the response valid.
module weighted_line_fit #(
   parameter int MAX_POINTS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_pos_z,
   input  logic signed [15:0] req_pos_t,
   input  logic [11:0]        req_weight,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_intercept,
   output logic signed [31:0] rsp_slope,
   output logic               rsp_fit_status
);

   // The point count must be able to hold MAX_POINTS itself.
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   // Sequencer.
   wlf_pkg::state_type state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic [2:0] term_ff, term_in;
   logic [wlf_pkg::QCNT_W-1:0] qcnt_ff, qcnt_in;

   // Latched request.
   logic signed [15:0] z_ff, z_in;
   logic signed [15:0] t_ff, t_in;
   logic [11:0] w_ff, w_in;
   logic last_ff, last_in;

   // Running sums of the current point set.
   logic [CNT_W-1:0] count_ff, count_in;
   logic [wlf_pkg::SW_W-1:0] sum_weight_ff, sum_weight_in;
   logic [wlf_pkg::S1_W-1:0] sum_wz_ff, sum_wz_in;
   logic [wlf_pkg::S1_W-1:0] sum_wt_ff, sum_wt_in;
   logic [wlf_pkg::S2_W-1:0] sum_wzz_ff, sum_wzz_in;
   logic [wlf_pkg::S2_W-1:0] sum_wzt_ff, sum_wzt_in;

   // Point multiplier with its output register; w*z is kept for the second-order products.
   logic signed [wlf_pkg::MA_W-1:0] mul_a;
   logic signed [wlf_pkg::MB_W-1:0] mul_b;
   logic signed [wlf_pkg::MP_W-1:0] mul_p;
   logic signed [wlf_pkg::MP_W-1:0] mul_ff, mul_in;
   logic signed [wlf_pkg::MA_W-1:0] wz_ff, wz_in;

   // Fit datapath. The wa register is the product accumulator during a multiplication
   // and the partial remainder during a division. The wb register is the shifting
   // multiplicand, then the shifting divisor. The mp register holds the multiplier
   // magnitude, then collects quotient bits.
   logic [wlf_pkg::WIDE_W-1:0] wa_ff, wa_in;
   logic [wlf_pkg::WIDE_W-1:0] wb_ff, wb_in;
   logic [wlf_pkg::MUL_W-1:0]  mp_ff, mp_in;
   logic [wlf_pkg::DEN_W-1:0]  den_ff, den_in;
   logic neg_ff, neg_in;

   // Result of the fit in progress.
   logic [wlf_pkg::Q_W-1:0] icpt_ff, icpt_in;
   logic [wlf_pkg::Q_W-1:0] slope_ff, slope_in;
   logic degen_ff, degen_in;

   // Output register.
   logic rsp_valid_ff, rsp_valid_in;
   logic [wlf_pkg::Q_W-1:0] rsp_icpt_ff, rsp_icpt_in;
   logic [wlf_pkg::Q_W-1:0] rsp_slope_ff, rsp_slope_in;
   logic rsp_status_ff, rsp_status_in;

   // The one wide adder. Its carry out is the compare result during division.
   logic [wlf_pkg::WIDE_W-1:0] add_a;
   logic [wlf_pkg::WIDE_W-1:0] add_b;
   logic add_ci;
   logic [wlf_pkg::WIDE_W:0] add_sum;

   // Operands of the current product term.
   logic [wlf_pkg::WIDE_W-1:0] sel_a;
   logic [wlf_pkg::MUL_W-1:0]  sel_b;
   logic [wlf_pkg::MUL_W-1:0]  mag_b;
   logic flip;

   // Rounded and saturated quotient.
   logic [wlf_pkg::Q_W-1:0] quo;
   logic [wlf_pkg::Q_W-1:0] quo_sat;

   assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{wlf_pkg::WIDE_W{1'b0}}, add_ci};
   assign mul_p   = mul_a * mul_b;

   // Requests are taken only while the sequencer is idle.
   assign req_stall      = (state_ff != wlf_pkg::S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_intercept  = rsp_icpt_ff;
   assign rsp_slope      = rsp_slope_ff;
   assign rsp_fit_status = rsp_status_ff;

   // Operand select for the point multiplier.
   always_comb begin
      case (step_ff)
         wlf_pkg::STEP_WZ: begin
            mul_a = {16'b0, w_ff};
            mul_b = z_ff;
         end
         wlf_pkg::STEP_WT: begin
            mul_a = {16'b0, w_ff};
            mul_b = t_ff;
         end
         wlf_pkg::STEP_WZZ: begin
            mul_a = wz_ff;
            mul_b = z_ff;
         end
         default: begin
            mul_a = wz_ff;
            mul_b = t_ff;
         end
      endcase
   end

   // Operands of each product term. The multiplicand is zero- (Szz) or sign-extended to
   // the adder width, the 2^16 slope scale folded in; the multiplier is at most 36 bits.
   always_comb begin
      case (term_ff)
         wlf_pkg::T_DEN_A: begin
            sel_a = {52'b0, sum_wzz_ff};
            sel_b = {16'b0, sum_weight_ff};
         end
         wlf_pkg::T_DEN_B: begin
            sel_a = {{68{sum_wz_ff[wlf_pkg::S1_W-1]}}, sum_wz_ff};
            sel_b = sum_wz_ff;
         end
         wlf_pkg::T_ICPT_A: begin
            sel_a = {52'b0, sum_wzz_ff};
            sel_b = sum_wt_ff;
         end
         wlf_pkg::T_ICPT_B: begin
            sel_a = {{52{sum_wzt_ff[wlf_pkg::S2_W-1]}}, sum_wzt_ff};
            sel_b = sum_wz_ff;
         end
         wlf_pkg::T_SLOPE_A: begin
            sel_a = {{36{sum_wzt_ff[wlf_pkg::S2_W-1]}}, sum_wzt_ff, 16'b0};
            sel_b = {16'b0, sum_weight_ff};
         end
         default: begin
            sel_a = {{52{sum_wt_ff[wlf_pkg::S1_W-1]}}, sum_wt_ff, 16'b0};
            sel_b = sum_wz_ff;
         end
      endcase
      mag_b = sel_b[wlf_pkg::MUL_W-1] ? (~sel_b + {{(wlf_pkg::MUL_W-1){1'b0}}, 1'b1}) : sel_b;
      // Odd terms are subtracted; a negative multiplier flips the sign once more.
      flip  = sel_b[wlf_pkg::MUL_W-1] ^ term_ff[0];
   end

   // The division yields round(|n| / D) as floor((2|n| + D) / 2D). Bit 31 set means
   // the magnitude reached 2^31 and the result saturates.
   always_comb begin
      quo = mp_ff[wlf_pkg::Q_W-1:0];
      if (quo[wlf_pkg::Q_W-1]) begin
         quo_sat = neg_ff ? {1'b1, {(wlf_pkg::Q_W-1){1'b0}}} : {1'b0, {(wlf_pkg::Q_W-1){1'b1}}};
      end else begin
         quo_sat = neg_ff ? (~quo + {{(wlf_pkg::Q_W-1){1'b0}}, 1'b1}) : quo;
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      term_in       = term_ff;
      qcnt_in       = qcnt_ff;
      z_in          = z_ff;
      t_in          = t_ff;
      w_in          = w_ff;
      last_in       = last_ff;
      count_in      = count_ff;
      sum_weight_in = sum_weight_ff;
      sum_wz_in     = sum_wz_ff;
      sum_wt_in     = sum_wt_ff;
      sum_wzz_in    = sum_wzz_ff;
      sum_wzt_in    = sum_wzt_ff;
      mul_in        = mul_ff;
      wz_in         = wz_ff;
      wa_in         = wa_ff;
      wb_in         = wb_ff;
      mp_in         = mp_ff;
      den_in        = den_ff;
      neg_in        = neg_ff;
      icpt_in       = icpt_ff;
      slope_in      = slope_ff;
      degen_in      = degen_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_icpt_in   = rsp_icpt_ff;
      rsp_slope_in  = rsp_slope_ff;
      rsp_status_in = rsp_status_ff;
      add_a         = '0;
      add_b         = '0;
      add_ci        = 1'b0;

      // A response that is taken leaves the output register free.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         wlf_pkg::S_IDLE: begin
            if (req_valid) begin
               z_in    = req_pos_z;
               t_in    = req_pos_t;
               w_in    = req_weight;
               last_in = req_last;
               // Points beyond MAX_POINTS are dropped, but a last flag still fits.
               if (count_ff < CNT_W'(MAX_POINTS)) begin
                  state_in = wlf_pkg::S_ACC;
                  step_in  = wlf_pkg::STEP_WZ;
               end else if (req_last) begin
                  state_in = wlf_pkg::S_LOAD;
                  term_in  = wlf_pkg::T_DEN_A;
               end
            end
         end

         // Each step launches a product and sums the prior one; the first sums the weight.
         wlf_pkg::S_ACC: begin
            mul_in  = mul_p;
            step_in = step_ff + 3'd1;
            case (step_ff)
               wlf_pkg::STEP_WZ: begin
                  sum_weight_in = sum_weight_ff + {8'b0, w_ff};
                  count_in      = count_ff + CNT_W'(1);
               end
               wlf_pkg::STEP_WT: begin
                  wz_in     = mul_ff[wlf_pkg::MA_W-1:0];
                  sum_wz_in = sum_wz_ff + mul_ff[wlf_pkg::S1_W-1:0];
               end
               wlf_pkg::STEP_WZZ: begin
                  sum_wt_in = sum_wt_ff + mul_ff[wlf_pkg::S1_W-1:0];
               end
               wlf_pkg::STEP_WZT: begin
                  sum_wzz_in = sum_wzz_ff + {8'b0, mul_ff};
               end
               default: begin
                  sum_wzt_in = sum_wzt_ff + {{8{mul_ff[wlf_pkg::MP_W-1]}}, mul_ff};
                  term_in    = wlf_pkg::T_DEN_A;
                  state_in   = last_ff ? wlf_pkg::S_LOAD : wlf_pkg::S_IDLE;
               end
            endcase
         end

         // Set up one product term. The adder negates the multiplicand when needed;
         // the first term of each pair starts the accumulator from zero.
         wlf_pkg::S_LOAD: begin
            add_b  = ~sel_a;
            add_ci = 1'b1;
            wb_in  = flip ? add_sum[wlf_pkg::WIDE_W-1:0] : sel_a;
            mp_in  = mag_b;
            if (!term_ff[0]) begin
               wa_in = '0;
            end
            state_in = wlf_pkg::S_MUL;
         end

         // Shift-add multiplication, least significant multiplier bit first. It ends
         // as soon as no multiplier bits are left.
         wlf_pkg::S_MUL: begin
            if (mp_ff == '0) begin
               if (term_ff == wlf_pkg::T_DEN_B) begin
                  state_in = wlf_pkg::S_TEST;
               end else if (term_ff[0]) begin
                  state_in = wlf_pkg::S_ABS;
               end else begin
                  term_in  = term_ff + 3'd1;
                  state_in = wlf_pkg::S_LOAD;
               end
            end else begin
               add_a = wa_ff;
               add_b = mp_ff[0] ? wb_ff : '0;
               wa_in = add_sum[wlf_pkg::WIDE_W-1:0];
               wb_in = {wb_ff[wlf_pkg::WIDE_W-2:0], 1'b0};
               mp_in = {1'b0, mp_ff[wlf_pkg::MUL_W-1:1]};
            end
         end

         // A denominator of zero means all weight sits at one z, or there is none.
         wlf_pkg::S_TEST: begin
            if (wa_ff[wlf_pkg::WIDE_W-1] || (wa_ff == '0)) begin
               icpt_in  = '0;
               slope_in = '0;
               degen_in = 1'b1;
               state_in = wlf_pkg::S_OUT;
            end else begin
               den_in   = wa_ff[wlf_pkg::DEN_W-1:0];
               term_in  = wlf_pkg::T_ICPT_A;
               state_in = wlf_pkg::S_LOAD;
            end
         end

         // Take the numerator magnitude and line the divisor 2D up with quotient bit 31.
         wlf_pkg::S_ABS: begin
            add_b  = ~wa_ff;
            add_ci = 1'b1;
            neg_in = wa_ff[wlf_pkg::WIDE_W-1];
            if (wa_ff[wlf_pkg::WIDE_W-1]) begin
               wa_in = add_sum[wlf_pkg::WIDE_W-1:0];
            end
            wb_in    = {den_ff, {(wlf_pkg::WIDE_W-wlf_pkg::DEN_W){1'b0}}};
            state_in = wlf_pkg::S_PREP;
         end

         // Dividend 2|n| + D gives rounding to nearest with ties away from zero.
         wlf_pkg::S_PREP: begin
            add_a    = {wa_ff[wlf_pkg::WIDE_W-2:0], 1'b0};
            add_b    = {{(wlf_pkg::WIDE_W-wlf_pkg::DEN_W){1'b0}}, den_ff};
            wa_in    = add_sum[wlf_pkg::WIDE_W-1:0];
            qcnt_in  = '0;
            state_in = wlf_pkg::S_DIV;
         end

         // Restoring division, one quotient bit per cycle with a right-shifting divisor.
         wlf_pkg::S_DIV: begin
            add_a  = wa_ff;
            add_b  = ~wb_ff;
            add_ci = 1'b1;
            if (add_sum[wlf_pkg::WIDE_W]) begin
               wa_in = add_sum[wlf_pkg::WIDE_W-1:0];
            end
            mp_in   = {mp_ff[wlf_pkg::MUL_W-2:0], add_sum[wlf_pkg::WIDE_W]};
            wb_in   = {1'b0, wb_ff[wlf_pkg::WIDE_W-1:1]};
            qcnt_in = qcnt_ff + {{(wlf_pkg::QCNT_W-1){1'b0}}, 1'b1};
            if (qcnt_ff == '1) begin
               state_in = wlf_pkg::S_DONE;
            end
         end

         wlf_pkg::S_DONE: begin
            if (term_ff == wlf_pkg::T_ICPT_B) begin
               icpt_in  = quo_sat;
               term_in  = wlf_pkg::T_SLOPE_A;
               state_in = wlf_pkg::S_LOAD;
            end else begin
               slope_in = quo_sat;
               degen_in = 1'b0;
               state_in = wlf_pkg::S_OUT;
            end
         end

         // Hand the result over once the output register is free, and start a new set.
         wlf_pkg::S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_icpt_in   = icpt_ff;
               rsp_slope_in  = slope_ff;
               rsp_status_in = degen_ff;
               count_in      = '0;
               sum_weight_in = '0;
               sum_wz_in     = '0;
               sum_wt_in     = '0;
               sum_wzz_in    = '0;
               sum_wzt_in    = '0;
               state_in      = wlf_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = wlf_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wlf_pkg::S_IDLE;
         count_ff      <= '0;
         sum_weight_ff <= '0;
         sum_wz_ff     <= '0;
         sum_wt_ff     <= '0;
         sum_wzz_ff    <= '0;
         sum_wzt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         sum_weight_ff <= sum_weight_in;
         sum_wz_ff     <= sum_wz_in;
         sum_wt_ff     <= sum_wt_in;
         sum_wzz_ff    <= sum_wzz_in;
         sum_wzt_ff    <= sum_wzt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      term_ff       <= term_in;
      qcnt_ff       <= qcnt_in;
      z_ff          <= z_in;
      t_ff          <= t_in;
      w_ff          <= w_in;
      last_ff       <= last_in;
      mul_ff        <= mul_in;
      wz_ff         <= wz_in;
      wa_ff         <= wa_in;
      wb_ff         <= wb_in;
      mp_ff         <= mp_in;
      den_ff        <= den_in;
      neg_ff        <= neg_in;
      icpt_ff       <= icpt_in;
      slope_ff      <= slope_in;
      degen_ff      <= degen_in;
      rsp_icpt_ff   <= rsp_icpt_in;
      rsp_slope_ff  <= rsp_slope_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
